// ===== hdl/ctpdw_pkg.sv =====
// ----------------------------------------------------------------------------
// ctpdw_pkg
// Types, field widths and constants shared by the pixel footprint weight block.
// ----------------------------------------------------------------------------
package ctpdw_pkg;

	// configuration register widths
	localparam int IMG_W   = 11;
	localparam int DET_W   = 12;
	localparam int ANGC_W  = 11;
	localparam int DW_W    = 24;
	localparam int INV_W   = 22;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// item field widths
	localparam int ANG_W   = 10;
	localparam int TRIG_W  = 18;
	localparam int PIX_W   = 10;
	localparam int ROW_W   = 21;
	localparam int COL_W   = 20;
	localparam int WGT_W   = 24;
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 72;

	// datapath widths
	localparam int UV_W    = 28;  // centered pixel coordinate, Q16 signed
	localparam int PRJ_W   = 46;  // trig times coordinate
	localparam int SUM_W   = 47;
	localparam int P_W     = 31;  // projected position, Q16 signed
	localparam int PM_W    = 54;
	localparam int PC_W    = 39;
	localparam int BND_W   = 40;
	localparam int CELL_W  = 24;  // signed cell number
	localparam int HP_W    = 38;
	localparam int H_W     = 22;
	localparam int LEN_W   = 23;
	localparam int WP_W    = 47;

	localparam logic [15:0] HALF_DIAG_Q16 = 16'd46341;

	// cycles from input register to footprint bounds being valid
	localparam int CALC_LAT = 7;
	localparam int WAIT_W   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_SIZE     = 3'd0,
		CFG_DETECTOR_COUNT = 3'd1,
		CFG_ANGLE_COUNT    = 3'd2,
		CFG_DETECTOR_WIDTH = 3'd3,
		CFG_INV_DET_WIDTH  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_MULW,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [IMG_W-1:0]  image_size;
		logic [DET_W-1:0]  detector_count;
		logic [ANGC_W-1:0] angle_count;
		logic [DW_W-1:0]   detector_width;
		logic [INV_W-1:0]  inv_detector_width;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic cell_init;
		logic cell_next;
		logic load_out;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic angle_bad;
		logic empty;
		logic at_last_cell;
	} status_t;

endpackage

// ===== hdl/ct_pixel_detector_weights_top.sv =====
// ----------------------------------------------------------------------------
// ct_pixel_detector_weights_top
// Parallel-beam system-matrix weights for one pixel and one projection angle.
// ----------------------------------------------------------------------------
// One item (angle index, cos, sin, pixel x/y) is taken at a time. After it is
// accepted, the projection runs through a fixed chain of multiplies and adds
// before the touched detector cells are known; an item with an out-of-range
// angle index is dropped on acceptance, and one whose footprint misses the
// detector frees the input once the bounds are known, both with no result.
// Each touched cell then passes through a weight multiply state and an output
// register load, and any output stall holds the block in the load step.
// The last entry of an item is flagged on m_axis_tlast; at most MAX_ENTRIES
// entries are produced per item. The input is taken again as soon as the last
// entry sits in the output register.
module ct_pixel_detector_weights_top import ctpdw_pkg::*; #(
	parameter int MAX_IMAGE_SIZE = 1024,
	parameter int MAX_DETECTORS  = 2048,
	parameter int MAX_ANGLES     = 1024,
	parameter int MAX_ENTRIES    = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// angle_index[9:0], angle_cos[27:10], angle_sin[45:28],
	// pixel_x[55:46], pixel_y[65:56], zero fill
	input  logic [S_DATA_W-1:0]   s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// row_index[20:0], col_index[40:21], weight[64:41], zero fill
	output logic [M_DATA_W-1:0]   m_axis_tdata,
	output logic                  m_axis_tlast
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	ctpdw_cfg #(
		.MAX_IMAGE_SIZE (MAX_IMAGE_SIZE),
		.MAX_DETECTORS  (MAX_DETECTORS),
		.MAX_ANGLES     (MAX_ANGLES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ctpdw_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	ctpdw_dp u_dp (
		.clk      (clk),
		.cfg      (cfg),
		.in_data  (s_axis_tdata),
		.cmd      (cmd),
		.status   (status),
		.out_data (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule

// ===== hdl/ctpdw_cfg.sv =====
// ----------------------------------------------------------------------------
// ctpdw_cfg
// Configuration registers with width masking and saturation of the counts.
// ----------------------------------------------------------------------------
module ctpdw_cfg import ctpdw_pkg::*; #(
	parameter int MAX_IMAGE_SIZE = 1024,
	parameter int MAX_DETECTORS  = 2048,
	parameter int MAX_ANGLES     = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic [31:0] img_ext, det_ext, ang_ext;

	assign img_ext = 32'(cfg_wdata[IMG_W-1:0]);
	assign det_ext = 32'(cfg_wdata[DET_W-1:0]);
	assign ang_ext = 32'(cfg_wdata[ANGC_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_size         <= IMG_W'(256);
			cfg_q.detector_count     <= DET_W'(256);
			cfg_q.angle_count        <= ANGC_W'(180);
			cfg_q.detector_width     <= DW_W'(65536);
			cfg_q.inv_detector_width <= INV_W'(65536);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_IMAGE_SIZE: begin
					cfg_q.image_size <= (img_ext > 32'(MAX_IMAGE_SIZE)) ?
						IMG_W'(MAX_IMAGE_SIZE) : cfg_wdata[IMG_W-1:0];
				end
				CFG_DETECTOR_COUNT: begin
					cfg_q.detector_count <= (det_ext > 32'(MAX_DETECTORS)) ?
						DET_W'(MAX_DETECTORS) : cfg_wdata[DET_W-1:0];
				end
				CFG_ANGLE_COUNT: begin
					cfg_q.angle_count <= (ang_ext > 32'(MAX_ANGLES)) ?
						ANGC_W'(MAX_ANGLES) : cfg_wdata[ANGC_W-1:0];
				end
				CFG_DETECTOR_WIDTH: begin
					cfg_q.detector_width <= cfg_wdata[DW_W-1:0];
				end
				CFG_INV_DET_WIDTH: begin
					cfg_q.inv_detector_width <= cfg_wdata[INV_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/ctpdw_dp.sv =====
// ----------------------------------------------------------------------------
// ctpdw_dp
// Datapath: projection pipeline, footprint bounds, cell counter, weight
// multiply and output register.
// ----------------------------------------------------------------------------
module ctpdw_dp import ctpdw_pkg::*; (
	input  logic                clk,
	input  cfg_t                cfg,
	input  logic [S_DATA_W-1:0] in_data,
	input  cmd_t                cmd,
	output status_t             status,
	output logic [M_DATA_W-1:0] out_data,
	output logic                out_last
);

	// input register
	logic [ANG_W-1:0]         ang_q;
	logic signed [TRIG_W-1:0] cs_q, sn_q;
	logic [PIX_W-1:0]         x_q, y_q;

	logic signed [UV_W-1:0]   u_s1, v_s1;
	logic [ANG_W+DET_W-1:0]   row_base_s1;
	logic [PIX_W+IMG_W-1:0]   colp_s1;
	logic signed [PRJ_W-1:0]  pu_s2, pv_s2;
	logic [COL_W-1:0]         col_s2;
	logic signed [P_W-1:0]    p_s3;
	logic signed [PM_W-1:0]   pm_s4;
	logic signed [PC_W-1:0]   pc_s5;
	logic signed [BND_W-1:0]  lb_s6, hb_s6;
	logic signed [CELL_W-1:0] first_s7, lastc_s7;
	logic [HP_W-1:0]          hprod_q;

	logic signed [SUM_W-1:0]  sum_c;
	logic signed [CELL_W-1:0] lo, hi, last_lim, c_ext;
	logic [H_W-1:0]           h;
	logic [DET_W-1:0]         cell_q;

	logic [LEN_W-1:0]         len;
	logic                     inner;
	logic [WP_W-1:0]          wp_s1;
	logic                     inner_s1;
	logic [WGT_W-1:0]         wgt;
	logic [WP_W-17:0]         wsh;

	logic [ROW_W-1:0]         row_q;
	logic [COL_W-1:0]         col_q;
	logic [WGT_W-1:0]         wgt_q;
	logic                     last_q;
	logic [ANG_W+DET_W-1:0]   row_full;

	assign status.angle_bad = {1'b0, in_data[ANG_W-1:0]} >= cfg.angle_count;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ang_q <= in_data[9:0];
			cs_q  <= in_data[27:10];
			sn_q  <= in_data[45:28];
			x_q   <= in_data[55:46];
			y_q   <= in_data[65:56];
		end
	end

	assign sum_c = {pu_s2[PRJ_W-1], pu_s2} + {pv_s2[PRJ_W-1], pv_s2};
	assign h     = hprod_q[HP_W-1:16];

	// free-running pipeline; the controller waits until the bounds settle
	always_ff @(posedge clk) begin
		u_s1 <= $signed({2'b0, x_q, 1'b1, 15'b0}) - $signed({2'b0, cfg.image_size, 15'b0});
		v_s1 <= $signed({2'b0, cfg.image_size, 15'b0}) - $signed({2'b0, y_q, 1'b1, 15'b0});
		row_base_s1 <= ang_q * cfg.detector_count;
		colp_s1     <= y_q * cfg.image_size;
		pu_s2  <= cs_q * u_s1;
		pv_s2  <= sn_q * v_s1;
		col_s2 <= COL_W'(colp_s1 + {{IMG_W{1'b0}}, x_q});
		p_s3   <= sum_c[SUM_W-1:16];
		pm_s4  <= p_s3 * $signed({1'b0, cfg.inv_detector_width});
		pc_s5  <= $signed({pm_s4[PM_W-1], pm_s4[PM_W-1:16]})
			+ $signed({12'b0, cfg.detector_count, 15'b0});
		lb_s6  <= {pc_s5[PC_W-1], pc_s5} - $signed({18'b0, h});
		hb_s6  <= {pc_s5[PC_W-1], pc_s5} + $signed({18'b0, h});
		first_s7 <= lo[CELL_W-1] ? '0 : lo;
		lastc_s7 <= (hi > last_lim) ? last_lim : hi;
		hprod_q <= HALF_DIAG_Q16 * cfg.inv_detector_width;
	end

	assign lo       = lb_s6[BND_W-1:16];
	assign hi       = hb_s6[BND_W-1:16];
	assign last_lim = $signed({12'b0, cfg.detector_count}) - CELL_W'(1);

	assign status.empty = first_s7 > lastc_s7;

	// cell counter
	always_ff @(posedge clk) begin
		if (cmd.cell_init) begin
			cell_q <= first_s7[DET_W-1:0];
		end else if (cmd.cell_next) begin
			cell_q <= cell_q + DET_W'(1);
		end
	end

	assign c_ext = $signed({12'b0, cell_q});
	assign status.at_last_cell = c_ext == lastc_s7;

	// overlap length of the current cell
	always_comb begin
		inner = 1'b0;
		len   = '0;
		if (lo == hi) begin
			len = {h, 1'b0};
		end else if (c_ext == lo) begin
			len = LEN_W'(18'h10000 - {2'b0, lb_s6[15:0]});
		end else if (c_ext == hi) begin
			len = LEN_W'(hb_s6[15:0]);
		end else begin
			inner = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		wp_s1    <= len * cfg.detector_width;
		inner_s1 <= inner;
	end

	assign wsh = wp_s1[WP_W-1:16];
	always_comb begin
		if (inner_s1) begin
			wgt = cfg.detector_width;
		end else if (|wsh[WP_W-17:WGT_W]) begin
			wgt = '1;
		end else begin
			wgt = wsh[WGT_W-1:0];
		end
	end

	assign row_full = row_base_s1 + {{ANG_W{1'b0}}, cell_q};

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			row_q  <= row_full[ROW_W-1:0];
			col_q  <= col_s2;
			wgt_q  <= wgt;
			last_q <= cmd.last;
		end
	end

	assign out_data = {7'b0, wgt_q, col_q, row_q};
	assign out_last = last_q;

endmodule

// ===== hdl/ctpdw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctpdw_ctrl
// Controller: input handshake, pipeline wait, per-cell sequencing and
// output valid.
// ----------------------------------------------------------------------------
module ctpdw_ctrl import ctpdw_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam int N_W = $clog2(MAX_ENTRIES);

	state_t            state_q, state_d;
	logic [WAIT_W-1:0] wait_q, wait_d;
	logic [N_W-1:0]    n_q, n_d;
	logic              valid_q;
	logic              last;

	assign last = status.at_last_cell || (n_q == N_W'(MAX_ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q  <= '0;
			n_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wait_q  <= wait_d;
			n_q     <= n_d;
			if (cmd.load_out) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		wait_d   = wait_q;
		n_d      = n_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					wait_d      = '0;
					if (!status.angle_bad) begin
						state_d = ST_CALC;
					end
				end
			end
			ST_CALC: begin
				if (wait_q == WAIT_W'(CALC_LAT)) begin
					if (status.empty) begin
						state_d = ST_IDLE;
					end else begin
						cmd.cell_init = 1'b1;
						n_d           = '0;
						state_d       = ST_MULW;
					end
				end else begin
					wait_d = wait_q + WAIT_W'(1);
				end
			end
			ST_MULW: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					cmd.last     = last;
					if (last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.cell_next = 1'b1;
						n_d           = n_q + N_W'(1);
						state_d       = ST_MULW;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = valid_q;

endmodule

// ===== verif/tb_ct_pixel_detector_weights_top.sv =====
// ----------------------------------------------------------------------------
// tb_ct_pixel_detector_weights_top
// Self-checking bench for the parallel-beam pixel footprint weight block.
// ----------------------------------------------------------------------------
// Pixel/angle items go in on the slave stream. A scoreboard predicts the
// detector-cell weights of every accepted item and compares each entry leaving
// the master stream in order. Directed items cover the edges of the fields,
// out-of-range angles, cells off the detector, one-cell footprints, the entry
// cap and zero registers; random phases then vary the registers, the sender
// bursts and the receiver stalls, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_ct_pixel_detector_weights_top;
	import ctpdw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_IMAGE_SIZE = 1024;
	localparam int MAX_DETECTORS  = 2048;
	localparam int MAX_ANGLES     = 1024;
	localparam int MAX_ENTRIES    = 64;

	localparam longint HALF_DIAG  = 46341;  // sqrt(2)/2 in Q16
	localparam int DRAIN_CYCLES   = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int RAND_PHASES    = 6;
	localparam int RAND_ITEMS     = 32;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [WGT_W-1:0] wgt;
		logic             last;
	} entry_t;

	class weight_board;
		bit [IMG_W-1:0]  img_size;
		bit [DET_W-1:0]  det_cnt;
		bit [ANGC_W-1:0] ang_cnt;
		bit [DW_W-1:0]   det_w;
		bit [INV_W-1:0]  inv_w;
		entry_t          weight_q[$];
		int              errors;

		function new();
			img_size = 256;
			det_cnt  = 256;
			ang_cnt  = 180;
			det_w    = 65536;
			inv_w    = 65536;
			errors   = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("ERROR: %s", msg);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_IMAGE_SIZE: begin
					img_size = (val[IMG_W-1:0] > MAX_IMAGE_SIZE) ? MAX_IMAGE_SIZE : val[IMG_W-1:0];
				end
				CFG_DETECTOR_COUNT: begin
					det_cnt = (val[DET_W-1:0] > MAX_DETECTORS) ? MAX_DETECTORS : val[DET_W-1:0];
				end
				CFG_ANGLE_COUNT: begin
					ang_cnt = (val[ANGC_W-1:0] > MAX_ANGLES) ? MAX_ANGLES : val[ANGC_W-1:0];
				end
				CFG_DETECTOR_WIDTH: det_w = val[DW_W-1:0];
				CFG_INV_DET_WIDTH:  inv_w = val[INV_W-1:0];
				default: ;
			endcase
		endfunction

		function longint overlap_weight(longint len);
			longint w;
			if (len <= 0)
				return 0;
			w = (len * longint'(det_w)) >>> 16;
			return (w > 24'hFFFFFF) ? 24'hFFFFFF : w;
		endfunction

		// project one pixel and queue the weight of every touched cell, up to MAX_ENTRIES
		function void note_pixel(logic [S_DATA_W-1:0] d);
			longint ang, cs, sn, x, y, ctr, u, v, p, pc, h, lb, hb, lo, hi;
			longint first, lastc, cnt, c, w;
			entry_t e;
			ang = d[9:0];
			cs  = $signed(d[27:10]);
			sn  = $signed(d[45:28]);
			x   = d[55:46];
			y   = d[65:56];
			if (ang >= ang_cnt)
				return;
			ctr = longint'(img_size) * 32768;
			u   = x * 65536 + 32768 - ctr;
			v   = ctr - y * 65536 - 32768;
			p   = (cs * u + sn * v) >>> 16;
			pc  = ((p * longint'(inv_w)) >>> 16) + longint'(det_cnt) * 32768;
			h   = (HALF_DIAG * longint'(inv_w)) >>> 16;
			lb  = pc - h;
			hb  = pc + h;
			lo  = lb >>> 16;
			hi  = hb >>> 16;
			first = (lo < 0) ? 0 : lo;
			lastc = (hi > longint'(det_cnt) - 1) ? longint'(det_cnt) - 1 : hi;
			cnt   = lastc - first + 1;
			if (cnt > MAX_ENTRIES)
				cnt = MAX_ENTRIES;
			for (longint k = 0; k < cnt; k++) begin
				c = first + k;
				if (lo == hi)
					w = overlap_weight(hb - lb);
				else if (c == lo)
					w = overlap_weight(65536 - (lb - lo * 65536));
				else if (c == hi)
					w = overlap_weight(hb - hi * 65536);
				else
					w = det_w;
				e.row  = ROW_W'(ang * longint'(det_cnt) + c);
				e.col  = COL_W'(y * longint'(img_size) + x);
				e.wgt  = WGT_W'(w);
				e.last = (k == cnt - 1);
				weight_q.push_back(e);
			end
		endfunction

		function void check_entry(logic [M_DATA_W-1:0] d, logic last);
			entry_t got, exp_e;
			got.row  = d[20:0];
			got.col  = d[40:21];
			got.wgt  = d[64:41];
			got.last = last;
			if (weight_q.size() == 0) begin
				flag($sformatf("entry with none pending: row %0d col %0d weight %0h last %0b",
					got.row, got.col, got.wgt, got.last));
				return;
			end
			exp_e = weight_q.pop_front();
			if (got !== exp_e)
				flag($sformatf({"entry mismatch: exp row %0d col %0d weight %0h last %0b, ",
					"got row %0d col %0d weight %0h last %0b"},
					exp_e.row, exp_e.col, exp_e.wgt, exp_e.last,
					got.row, got.col, got.wgt, got.last));
		endfunction

		function int pending();
			return weight_q.size();
		endfunction

		function void close_out();
			if (weight_q.size() != 0)
				flag($sformatf("%0d entries never arrived", weight_q.size()));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic                  m_axis_tlast;

	weight_board sb;

	// sender pacing and receiver pattern, set per phase
	bit gap_on = 1'b1;
	int rx_mode = 0;
	int hold_req = 0;
	int burst_left = 0;

	ct_pixel_detector_weights_top #(
		.MAX_IMAGE_SIZE (MAX_IMAGE_SIZE),
		.MAX_DETECTORS  (MAX_DETECTORS),
		.MAX_ANGLES     (MAX_ANGLES),
		.MAX_ENTRIES    (MAX_ENTRIES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// receiver: long hold-off on request, otherwise the phase's stall pattern
	int  hold_seen = 0;
	int  hold_left = 0;
	int  run_left = 0;
	bit  rx_on = 1'b1;
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				default: begin
					if (run_left == 0) begin
						rx_on = !rx_on;
						run_left = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
					end
					run_left--;
					m_axis_tready <= rx_on;
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_entry(m_axis_tdata, m_axis_tlast);
	end

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int img, input int dc, input int ac, input int dw,
			input int inv);
		write_cfg(CFG_IMAGE_SIZE,     CFG_DATA_W'(img));
		write_cfg(CFG_DETECTOR_COUNT, CFG_DATA_W'(dc));
		write_cfg(CFG_ANGLE_COUNT,    CFG_DATA_W'(ac));
		write_cfg(CFG_DETECTOR_WIDTH, CFG_DATA_W'(dw));
		write_cfg(CFG_INV_DET_WIDTH,  CFG_DATA_W'(inv));
	endtask

	task automatic send_pixel(input int ang, input int cs, input int sn, input int px,
			input int py);
		logic [S_DATA_W-1:0] d;
		int gap;
		d = '0;
		d[9:0]   = 10'(ang);
		d[27:10] = 18'(cs);
		d[45:28] = 18'(sn);
		d[55:46] = 10'(px);
		d[65:56] = 10'(py);
		s_axis_tdata  <= d;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(d);
		if (gap_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 8);
				gap = $urandom_range(1, 6);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// wait until every predicted entry is out and any silent item has cleared
	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stim
		int img, dc, ac, dw, inv, ang, cs, sn, px, py;
		longint base;
		real th;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		rx_mode = 1;
		send_pixel(0, 65536, 0, 128, 128);
		send_pixel(179, 0, 65536, 0, 0);
		send_pixel(180, 65536, 0, 10, 10);
		send_pixel(1023, -65536, 0, 255, 255);
		send_pixel(45, 46341, 46341, 255, 0);
		send_pixel(90, -65536, 0, 0, 255);
		send_pixel(0, 0, -65536, 7, 200);
		send_pixel(10, 131071, -131072, 1023, 1023);
		send_pixel(10, -131072, 131071, 1023, 0);
		send_pixel(0, 65536, 0, 0, 0);
		drain_block();

		// wide cells: footprints mostly inside one cell
		set_config(4, 8, 2, 24'hFFFFFF, 16384);
		rx_mode = 2;
		send_pixel(0, 65536, 0, 0, 0);
		send_pixel(1, 0, 65536, 3, 3);
		send_pixel(1, 46341, -46341, 2, 1);
		send_pixel(2, 65536, 0, 1, 1);
		send_pixel(0, 65536, 0, 2, 0);
		drain_block();

		// saturating writes, widest footprint: entry cap, long output hold-off
		set_config(24'h0007FF, 24'h000FFF, 24'hFFFFFF, 65536, 24'h3FFFFF);
		hold_req++;
		send_pixel(1023, 65536, 0, 512, 512);
		send_pixel(0, 46341, 46341, 1023, 1023);
		send_pixel(500, -65536, 0, 0, 1023);
		drain_block();

		// zero registers and unused register indexes
		set_config(0, 0, 0, 0, 0);
		write_cfg(3'd5, 24'hFFFFFF);
		write_cfg(3'd7, 24'hAAAAAA);
		send_pixel(0, 65536, 0, 5, 5);
		drain_block();
		write_cfg(CFG_ANGLE_COUNT, 1);
		send_pixel(0, 65536, 0, 5, 5);
		drain_block();
		write_cfg(CFG_DETECTOR_COUNT, 1);
		send_pixel(0, 65536, 0, 0, 0);
		send_pixel(0, -65536, 65536, 1023, 1023);
		drain_block();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0)
				img = 1;
			else if (ph == RAND_PHASES - 1)
				img = MAX_IMAGE_SIZE;
			else
				img = $urandom_range(2, 64);
			dc = $urandom_range(img, 4 * img + 8);
			if (dc > MAX_DETECTORS)
				dc = MAX_DETECTORS;
			ac = $urandom_range(1, MAX_ANGLES);
			dw = ($urandom_range(0, 2) == 0) ? 65536 : $urandom_range(1, 24'hFFFFFF);
			base = (longint'(dc) * 40960) / img;
			base = base * $urandom_range(50, 150) / 100;
			inv = (base < 1) ? 1 : (base > 2818048) ? 2818048 : int'(base);
			// junk in the bits above each register's width
			write_cfg(CFG_IMAGE_SIZE,     {13'($urandom), 11'(img)});
			write_cfg(CFG_DETECTOR_COUNT, {12'($urandom), 12'(dc)});
			write_cfg(CFG_ANGLE_COUNT,    {13'($urandom), 11'(ac)});
			write_cfg(CFG_DETECTOR_WIDTH, 24'(dw));
			write_cfg(CFG_INV_DET_WIDTH,  {2'($urandom), 22'(inv)});
			rx_mode = ph % 3;
			gap_on  = (ph % 2 == 0);
			if (ph == 3)
				hold_req++;
			for (int i = 0; i < RAND_ITEMS; i++) begin
				if ($urandom_range(0, 7) == 0)
					ang = $urandom_range(0, 1023);
				else
					ang = $urandom_range(0, ac - 1);
				if ($urandom_range(0, 9) == 0) begin
					cs = $urandom;
					sn = $urandom;
				end else begin
					th = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
					cs = $rtoi($cos(th) * 65536.0);
					sn = $rtoi($sin(th) * 65536.0);
				end
				if ($urandom_range(0, 9) == 0) begin
					px = $urandom_range(0, 1023);
					py = $urandom_range(0, 1023);
				end else begin
					px = $urandom_range(0, img - 1);
					py = $urandom_range(0, img - 1);
				end
				send_pixel(ang, cs, sn, px, py);
			end
			drain_block();
		end

		sb.close_out();
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
